>>> hdl/tcpe_pkg.sv
// Shared types and constants for the terminal capability parameter expander.
`default_nettype none

package tcpe_pkg;

  typedef struct packed {
    logic [7:0]         cap_byte;
    logic               first;
    logic signed [15:0] start_value;
    logic               no_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic [1:0] status;
  } out_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef enum logic [1:0] {
    K_CHAR,
    K_END,
    K_ERR
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       clr;
    logic [7:0] ch;
    logic [1:0] status;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic signed [15:0] value;
    logic               sel100;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] quot;
    logic signed [15:0] rem;
  } div_rsp_t;

  localparam int Q_DEPTH = 4;

  localparam logic [15:0] RECIP10     = 16'd52429;
  localparam logic [15:0] RECIP100    = 16'd5243;
  localparam int          RECIP_SHIFT = 19;

  function automatic logic [7:0] digit_char(logic signed [15:0] v);
    return v[7:0] | 8'h30;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tcpe_div.sv
// Signed 16-bit divide by ten or one hundred, truncating.
`default_nettype none

module tcpe_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tcpe_pkg::div_req_t req,
  output tcpe_pkg::div_rsp_t      rsp
);
  import tcpe_pkg::*;

  logic        v0, v1;
  logic [15:0] mag0, mag1;
  logic        neg0, neg1;
  logic        sel0, sel1;
  logic [12:0] q1;
  logic [31:0] prod;
  logic [15:0] rmag;
  logic [15:0] qmag;

  assign prod = mag0 * (sel0 ? RECIP100 : RECIP10);
  assign qmag = {3'b000, q1};
  assign rmag = mag1 - 16'(qmag * (sel1 ? 16'd100 : 16'd10));

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      v0       <= req.start;
      v1       <= v0;
      rsp.done <= v1;
    end
    if (req.start) begin
      mag0 <= req.value[15] ? 16'(-req.value) : 16'(req.value);
      neg0 <= req.value[15];
      sel0 <= req.sel100;
    end
    if (v0) begin
      q1   <= prod[RECIP_SHIFT +: 13];
      mag1 <= mag0;
      neg1 <= neg0;
      sel1 <= sel0;
    end
    if (v1) begin
      rsp.quot <= neg1 ? -$signed(qmag) : $signed(qmag);
      rsp.rem  <= neg1 ? -$signed(rmag) : $signed(rmag);
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst) req.start |-> ##3 rsp.done)
    else $error("divide result did not arrive three cycles after start");

endmodule

`default_nettype wire

>>> hdl/tcpe_fifo.sv
// Short queue of expansion entries between the parser and the output stage.
`default_nettype none

module tcpe_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire tcpe_pkg::entry_t wdata,
  output logic                  full,
  input  wire logic             rd,
  output tcpe_pkg::entry_t      rdata,
  output logic                  empty
);
  import tcpe_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  entry_t        mem [Q_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) wr |-> !full)
    else $error("entry written into a full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) rd |-> !empty)
    else $error("entry read from an empty queue");

endmodule

`default_nettype wire

>>> hdl/tcpe_front.sv
// Parser: accepts capability bytes, tracks the escape state and the parameter.
`default_nettype none

module tcpe_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire tcpe_pkg::in_t      din,
  input  wire logic               q_full,
  output logic                    q_wr,
  output tcpe_pkg::entry_t        q_data,
  output tcpe_pkg::div_req_t      div_req,
  input  wire tcpe_pkg::div_rsp_t div_rsp
);
  import tcpe_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL,
    M_PCT,
    M_GT_X,
    M_GT_Y,
    M_PLUS,
    M_IDLE
  } mode_t;

  typedef enum logic [1:0] {
    F_ACCEPT,
    F_WAIT,
    F_PUSH_Q,
    F_PUSH_R
  } fstate_t;

  typedef enum logic [1:0] {
    J_ONE,
    J_TWO,
    J_THREE,
    J_BCD
  } job_t;

  localparam logic [7:0] C_NUL     = 8'h00;
  localparam logic [7:0] C_PERCENT = 8'h25;
  localparam logic [7:0] C_PLUS    = 8'h2B;
  localparam logic [7:0] C_DOT     = 8'h2E;
  localparam logic [7:0] C_TWO     = 8'h32;
  localparam logic [7:0] C_THREE   = 8'h33;
  localparam logic [7:0] C_GT      = 8'h3E;
  localparam logic [7:0] C_BCD     = 8'h42;
  localparam logic [7:0] C_RBCD    = 8'h44;
  localparam logic [7:0] C_DEC     = 8'h64;
  localparam logic [7:0] C_INC     = 8'h69;
  localparam logic [7:0] C_XOR     = 8'h6E;
  localparam logic [15:0] XOR_MASK = 16'h0060;

  fstate_t            state, state_next;
  mode_t              mode, mode_next, mode_in;
  job_t               job, job_next, job_sel;
  logic signed [15:0] param, param_next;
  logic [7:0]         cmp, cmp_next;
  logic               clr_pend, clr_next;

  logic               accept;
  logic [7:0]         b;
  logic signed [15:0] n_in, sb, scmp, n_neg, rem16, n_plus;

  assign full   = (state != F_ACCEPT) || q_full;
  assign accept = push && !full;
  assign b      = din.cap_byte;
  assign n_in   = din.first ? din.start_value : param;
  assign mode_in = din.first ? M_NORMAL : mode;
  assign sb     = {{8{b[7]}}, b};
  assign scmp   = {{8{cmp[7]}}, cmp};
  assign n_neg  = -n_in;
  assign rem16  = n_in[15] ? -$signed({12'd0, n_neg[3:0]}) : $signed({12'd0, n_in[3:0]});
  assign n_plus = n_in + sb;

  always_comb begin
    priority if (b == C_TWO) begin
      job_sel = J_TWO;
    end else if (b == C_DEC && n_in >= 16'sd10 && n_in < 16'sd100) begin
      job_sel = J_TWO;
    end else if (b == C_DEC && n_in < 16'sd10) begin
      job_sel = J_ONE;
    end else if (b == C_BCD) begin
      job_sel = J_BCD;
    end else begin
      job_sel = J_THREE;
    end
  end

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    job_next       = job;
    param_next     = param;
    cmp_next       = cmp;
    clr_next       = clr_pend;
    q_wr           = 1'b0;
    q_data.kind    = K_CHAR;
    q_data.clr     = clr_pend || (accept && din.first);
    q_data.ch      = b;
    q_data.status  = ST_OK;
    div_req.start  = 1'b0;
    div_req.value  = n_in;
    div_req.sel100 = (job_sel == J_THREE);
    unique case (state)
      F_ACCEPT: begin
        if (accept) begin
          param_next = n_in;
          mode_next  = mode_in;
          if (din.first) begin
            clr_next = 1'b1;
            cmp_next = '0;
          end
          if (din.first && din.no_string) begin
            q_wr          = 1'b1;
            q_data.kind   = K_ERR;
            q_data.status = ST_NONE;
            mode_next     = M_IDLE;
          end else begin
            unique case (mode_in)
              M_NORMAL: begin
                if (b == C_NUL) begin
                  q_wr        = 1'b1;
                  q_data.kind = K_END;
                  mode_next   = M_IDLE;
                end else if (b == C_PERCENT) begin
                  mode_next = M_PCT;
                end else begin
                  q_wr = 1'b1;
                end
              end
              M_PCT: begin
                mode_next = M_NORMAL;
                unique case (b)
                  C_XOR:  param_next = n_in ^ XOR_MASK;
                  C_DEC, C_TWO, C_THREE, C_BCD: begin
                    div_req.start = 1'b1;
                    job_next      = job_sel;
                    state_next    = F_WAIT;
                  end
                  C_GT:   mode_next = M_GT_X;
                  C_PLUS: mode_next = M_PLUS;
                  C_DOT: begin
                    q_wr      = 1'b1;
                    q_data.ch = n_in[7:0];
                  end
                  C_INC:  param_next = n_in + 16'sd1;
                  C_PERCENT: q_wr = 1'b1;
                  C_RBCD: param_next = n_in - (rem16 <<< 1);
                  default: begin
                    q_wr          = 1'b1;
                    q_data.kind   = K_ERR;
                    q_data.status = ST_BAD;
                    mode_next     = M_IDLE;
                  end
                endcase
              end
              M_GT_X, M_GT_Y, M_PLUS: begin
                if (b == C_NUL) begin
                  q_wr          = 1'b1;
                  q_data.kind   = K_ERR;
                  q_data.status = ST_BAD;
                  mode_next     = M_IDLE;
                end else if (mode_in == M_GT_X) begin
                  cmp_next  = b;
                  mode_next = M_GT_Y;
                end else if (mode_in == M_GT_Y) begin
                  if (n_in > scmp) begin
                    param_next = n_plus;
                  end
                  mode_next = M_NORMAL;
                end else begin
                  param_next = n_plus;
                  q_wr       = 1'b1;
                  q_data.ch  = n_plus[7:0];
                  mode_next  = M_NORMAL;
                end
              end
              default: mode_next = M_IDLE;
            endcase
          end
        end
      end
      F_WAIT: begin
        if (div_rsp.done) begin
          unique case (job)
            J_BCD: begin
              param_next = {div_rsp.quot[11:0], 4'b0000} + div_rsp.rem;
              state_next = F_ACCEPT;
            end
            J_ONE:   state_next = F_PUSH_R;
            default: state_next = F_PUSH_Q;
          endcase
        end
      end
      F_PUSH_Q: begin
        if (!q_full) begin
          q_wr      = 1'b1;
          q_data.ch = digit_char(div_rsp.quot);
          if (job == J_THREE) begin
            param_next     = div_rsp.rem;
            div_req.start  = 1'b1;
            div_req.value  = div_rsp.rem;
            div_req.sel100 = 1'b0;
            job_next       = J_TWO;
            state_next     = F_WAIT;
          end else begin
            state_next = F_PUSH_R;
          end
        end
      end
      F_PUSH_R: begin
        if (!q_full) begin
          q_wr       = 1'b1;
          q_data.ch  = digit_char(div_rsp.rem);
          state_next = F_ACCEPT;
        end
      end
      default: state_next = F_ACCEPT;
    endcase
    if (q_wr) begin
      clr_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_ACCEPT;
      mode     <= M_NORMAL;
      job      <= J_ONE;
      param    <= '0;
      cmp      <= '0;
      clr_pend <= 1'b0;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      job      <= job_next;
      param    <= param_next;
      cmp      <= cmp_next;
      clr_pend <= clr_next;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == F_WAIT)
    else $error("divide result arrived outside the wait state");

endmodule

`default_nettype wire

>>> hdl/tcpe_back.sv
// Output stage: counts characters, drops overflow, builds terminator status.
`default_nettype none

module tcpe_back #(
  parameter int OUT_CHARS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tcpe_pkg::entry_t head,
  input  wire logic             head_empty,
  output logic                  take,
  output logic                  empty,
  input  wire logic             pop,
  output tcpe_pkg::out_t        dout
);
  import tcpe_pkg::*;

  localparam int CW = $clog2(OUT_CHARS);
  localparam logic [CW-1:0] MAX_CHARS = CW'(OUT_CHARS - 1);

  logic [CW-1:0] cnt, cnt_eff, cnt_next;
  logic          ovf, ovf_eff, ovf_next;
  logic          result_valid, result_valid_next;
  out_t          result;
  logic          room;

  assign empty   = !result_valid;
  assign dout    = result;
  assign room    = !result_valid || pop;
  assign take    = !head_empty && room;
  assign cnt_eff = head.clr ? '0 : cnt;
  assign ovf_eff = head.clr ? 1'b0 : ovf;

  always_comb begin
    cnt_next          = cnt;
    ovf_next          = ovf;
    result_valid_next = result_valid && !pop;
    if (take) begin
      cnt_next = cnt_eff;
      ovf_next = ovf_eff;
      unique case (head.kind)
        K_CHAR: begin
          if (cnt_eff < MAX_CHARS) begin
            cnt_next          = cnt_eff + 1'b1;
            result_valid_next = 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
        end
        K_END, K_ERR: result_valid_next = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      cnt          <= cnt_next;
      ovf          <= ovf_next;
      result_valid <= result_valid_next;
    end
    if (take) begin
      unique case (head.kind)
        K_CHAR:  result <= '{out_char: head.ch, last: 1'b0, status: ST_OK};
        K_END:   result <= '{out_char: 8'd0, last: 1'b1, status: ovf_eff ? ST_OVF : ST_OK};
        default: result <= '{out_char: 8'd0, last: 1'b1, status: head.status};
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= MAX_CHARS)
    else $error("character count passed its limit");
  a_char_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> result.status == ST_OK)
    else $error("character word carries a nonzero status");

endmodule

`default_nettype wire

>>> hdl/terminal_cap_param_expander.sv
// Top level of the terminal capability parameter expander.
// Takes a capability string one byte per push word and returns the expanded
// characters, a closing terminator or one error word per string. Plain bytes
// and escapes that only change the parameter are accepted one per cycle while
// the queue has room, and result words drain through a four-entry queue and
// an output register one per cycle while pop is held. %2, %d, %B and %3 use
// the shared constant divide unit, and the parser waits for its results. At
// most OUT_CHARS-1 characters are sent per string; the rest are dropped and
// the terminator reports overflow.
`default_nettype none

module terminal_cap_param_expander #(
  parameter int OUT_CHARS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire tcpe_pkg::in_t  din,
  output logic                empty,
  input  wire logic           pop,
  output tcpe_pkg::out_t      dout
);
  import tcpe_pkg::*;

  logic     q_wr, q_full, q_empty, q_rd;
  entry_t   q_wdata, q_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  tcpe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .din     (din),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_data  (q_wdata),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  tcpe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tcpe_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tcpe_back #(
    .OUT_CHARS (OUT_CHARS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_rdata),
    .head_empty (q_empty),
    .take       (q_rd),
    .empty      (empty),
    .pop        (pop),
    .dout       (dout)
  );

endmodule

`default_nettype wire
